/* sv/cgs_pkg.sv */
// Package holding the shared types, codes and helpers of the contactor group supervisor.
`default_nettype none
package cgs_pkg;

  typedef enum logic [2:0] {
    ST_OFF    = 3'd0,
    ST_ONREQ  = 3'd1,
    ST_ONCONF = 3'd2,
    ST_OFFREQ = 3'd3,
    ST_FAULT  = 3'd4
  } grp_state_e;

  typedef enum logic [2:0] {
    F_NONE        = 3'd0,
    F_MISMATCH    = 3'd1,
    F_ON_TIMEOUT  = 3'd2,
    F_OFF_TIMEOUT = 3'd3,
    F_STUCK_ON    = 3'd4,
    F_UNEXP_OFF   = 3'd5
  } fault_e;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_ON        = 3'd1,
    OP_OFF       = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_SET_MASK  = 3'd4,
    OP_ALL_OFF   = 3'd5,
    OP_CLEAR_ALL = 3'd6,
    OP_INIT      = 3'd7
  } op_e;

  localparam logic [1:0] REG_ON_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_OFF_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_STABLE      = 2'd2;

  // Per-group record as held in the state registers.
  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  fault;
    logic        cmd;
    logic        drive;
    logic [31:0] state_t;
    logic [31:0] abn_t;
    logic        abn;
  } grp_rec_t;

  // Everything a lane needs about the request besides its own group.
  typedef struct packed {
    logic [2:0]  op;
    logic        sel;
    logic        cmd_bit;
    logic        fb_on;
    logic        fb_off;
    logic        fb_mis;
    logic [31:0] now;
    logic [31:0] on_to;
    logic [31:0] off_to;
    logic [31:0] stable;
  } lane_in_t;

  // What a lane reports to the merge stage.
  typedef struct packed {
    logic new_fault;
    logic cleared;
    logic ok;
  } lane_flags_t;

  function automatic logic rec_faulted(grp_rec_t r);
    return (r.mode == ST_FAULT) || (r.fault != F_NONE);
  endfunction

endpackage
`default_nettype wire

/* sv/cgs_if.sv */
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface cgs_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/contactor_group_supervisor_top.sv */
// Top level of the contactor group supervisor: state registers, lanes, merge and output register.
// The result is registered at the edge that accepts the request.
// Throughput: one request per cycle while results are taken; all groups are updated in parallel by one lane each.
// A result waiting in the output register blocks a new request until it is taken.
// Reset (asynchronous, active low): all groups off with no fault, timeouts 500/500/200 ms.
`default_nettype none
module contactor_group_supervisor_top
  import cgs_pkg::*;
#(
  parameter int GROUPS = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_idx_i,
  input  wire [31:0] cfg_data_i,
  cgs_if.sink        in_if,
  cgs_if.source      out_if
);

  logic [31:0] on_to_q, off_to_q, stable_q;
  grp_rec_t    rec_q [GROUPS];
  grp_rec_t    rec_d [GROUPS];
  lane_flags_t flags [GROUPS];
  logic        out_valid_q;
  logic        accept;

  logic        ok;
  logic [2:0]  gst, gflt;
  logic [7:0]  m_drv, m_cmd, m_conf, m_flt, m_new, m_clr;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept = in_if.valid && in_if.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_to_q <= 32'd500;
      off_to_q <= 32'd500;
      stable_q <= 32'd200;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ON_TIMEOUT: on_to_q <= cfg_data_i;
        REG_OFF_TIMEOUT: off_to_q <= cfg_data_i;
        REG_STABLE: stable_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // One lane per group.
  for (genvar g = 0; g < GROUPS; g++) begin : g_lane
    lane_in_t li;
    always_comb begin
      li.op = in_if.data.mode;
      li.sel = 32'(in_if.data.group) == g;
      li.now = in_if.data.now_ms;
      li.on_to = on_to_q;
      li.off_to = off_to_q;
      li.stable = stable_q;
      if (g < 8) begin
        li.cmd_bit = in_if.data.demand_mask[g % 8];
        li.fb_on = in_if.data.feedback_on[g % 8];
        li.fb_off = in_if.data.feedback_off[g % 8];
        li.fb_mis = in_if.data.feedback_mismatch[g % 8];
      end else begin
        li.cmd_bit = 1'b0;
        li.fb_on = 1'b0;
        li.fb_off = 1'b0;
        li.fb_mis = 1'b0;
      end
    end
    cgs_lane u_lane (.rec_i(rec_q[g]), .req_i(li), .rec_o(rec_d[g]), .flags_o(flags[g]));

    // Group state register.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rec_q[g] <= '0;
      end else if (accept) begin
        rec_q[g] <= rec_d[g];
      end
    end
  end

  cgs_merge #(.GROUPS(GROUPS)) u_merge (
    .rec_i(rec_d), .flags_i(flags), .op_i(in_if.data.mode), .group_i(in_if.data.group),
    .ok_o(ok), .group_state_o(gst), .group_fault_o(gflt),
    .drive_mask_o(m_drv), .commanded_mask_o(m_cmd), .confirmed_mask_o(m_conf),
    .faulted_mask_o(m_flt), .new_fault_mask_o(m_new), .cleared_mask_o(m_clr)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_if.data.ok <= ok;
      out_if.data.group_state <= gst;
      out_if.data.group_fault <= gflt;
      out_if.data.drive_mask <= m_drv;
      out_if.data.commanded_mask <= m_cmd;
      out_if.data.confirmed_mask <= m_conf;
      out_if.data.faulted_mask <= m_flt;
      out_if.data.new_fault_mask <= m_new;
      out_if.data.cleared_mask <= m_clr;
    end
  end

  assign out_if.valid = out_valid_q;

endmodule
`default_nettype wire

/* sv/cgs_lane.sv */
// One supervision lane: computes the next record of a single group for any operation.
`default_nettype none
module cgs_lane
  import cgs_pkg::*;
(
  input  wire grp_rec_t    rec_i,
  input  wire lane_in_t    req_i,
  output grp_rec_t         rec_o,
  output lane_flags_t      flags_o
);

  function automatic logic expired(logic [31:0] now, logic [31:0] st, logic [31:0] lim);
    logic [31:0] el;
    el = now - st;
    return el >= lim;
  endfunction

  // Next state of the group for the requested operation.
  always_comb begin
    grp_rec_t    r;
    logic        was;
    logic        on_act;
    logic        off_act;
    logic [2:0]  f;
    logic        fire;
    r = rec_i;
    was = rec_faulted(rec_i);
    flags_o = '0;
    flags_o.ok = 1'b1;
    on_act = 1'b0;
    off_act = 1'b0;
    f = F_NONE;
    fire = 1'b0;
    case (op_e'(req_i.op))
      OP_TICK: begin
        case (grp_state_e'(rec_i.mode))
          ST_OFF, ST_ONCONF: begin
            if ((rec_i.mode == ST_OFF) ? req_i.fb_off : req_i.fb_on) begin
              r.abn = 1'b0;
            end else begin
              if (!rec_i.abn) begin
                r.abn = 1'b1;
                r.abn_t = req_i.now;
              end
              if (expired(req_i.now, r.abn_t, req_i.stable)) begin
                fire = 1'b1;
                if (req_i.fb_mis) f = F_MISMATCH;
                else if (rec_i.mode == ST_ONCONF) f = F_UNEXP_OFF;
                else if (req_i.fb_on) f = F_STUCK_ON;
                else f = F_OFF_TIMEOUT;
              end
            end
          end
          ST_ONREQ: begin
            if (req_i.fb_on) begin
              r.mode = ST_ONCONF;
              r.fault = F_NONE;
              r.abn = 1'b0;
            end else if (expired(req_i.now, rec_i.state_t, req_i.on_to)) begin
              fire = 1'b1;
              f = req_i.fb_mis ? F_MISMATCH : F_ON_TIMEOUT;
            end
          end
          ST_OFFREQ: begin
            if (req_i.fb_off) begin
              r.mode = ST_OFF;
              r.fault = F_NONE;
              r.abn = 1'b0;
            end else if (expired(req_i.now, rec_i.state_t, req_i.off_to)) begin
              fire = 1'b1;
              if (req_i.fb_mis) f = F_MISMATCH;
              else if (req_i.fb_on) f = F_STUCK_ON;
              else f = F_OFF_TIMEOUT;
            end
          end
          default: begin
            r.drive = 1'b0;
            r.cmd = 1'b0;
            r.mode = ST_FAULT;
            r.abn = 1'b0;
            if (rec_i.fault == F_NONE) begin
              r.fault = F_UNEXP_OFF;
              flags_o.new_fault = !was;
            end
          end
        endcase
        if (fire) begin
          r.drive = 1'b0;
          r.cmd = 1'b0;
          r.mode = ST_FAULT;
          r.fault = f;
          r.abn = 1'b0;
          flags_o.new_fault = !was && (f != F_NONE);
        end
      end
      OP_ON: on_act = req_i.sel;
      OP_OFF: off_act = req_i.sel;
      OP_SET_MASK: begin
        off_act = !req_i.cmd_bit && (rec_i.cmd || rec_i.mode == ST_ONREQ
                                     || rec_i.mode == ST_ONCONF);
        on_act = req_i.cmd_bit && rec_i.mode == ST_OFF;
      end
      OP_ALL_OFF: off_act = 1'b1;
      OP_CLEAR, OP_CLEAR_ALL: begin
        if ((req_i.sel || req_i.op == OP_CLEAR_ALL) && was) begin
          r.drive = 1'b0;
          r.cmd = 1'b0;
          r.abn = 1'b0;
          r.state_t = req_i.now;
          if (req_i.fb_off) begin
            r.fault = F_NONE;
            r.mode = ST_OFF;
            flags_o.cleared = 1'b1;
          end else begin
            r.mode = ST_FAULT;
            flags_o.ok = 1'b0;
            if (req_i.fb_on) r.fault = F_STUCK_ON;
            else if (req_i.fb_mis) r.fault = F_MISMATCH;
            else r.fault = F_OFF_TIMEOUT;
          end
        end
      end
      default: begin
        r.drive = 1'b0;
        r.cmd = 1'b0;
        r.fault = F_NONE;
        r.abn = 1'b0;
        r.abn_t = req_i.now;
        r.state_t = req_i.now;
        r.mode = req_i.fb_off ? ST_OFF : ST_OFFREQ;
      end
    endcase
    // Request off, applied before any request on.
    if (off_act) begin
      r.cmd = 1'b0;
      r.abn = 1'b0;
      r.drive = 1'b0;
      if (!(rec_i.mode == ST_FAULT || rec_i.mode == ST_OFFREQ
            || (rec_i.mode == ST_OFF && req_i.fb_off))) begin
        r.mode = ST_OFFREQ;
        r.state_t = req_i.now;
      end
    end
    // Request on.
    if (on_act) begin
      if (rec_i.mode == ST_ONREQ || rec_i.mode == ST_ONCONF) begin
        r.cmd = 1'b1;
      end else if (rec_i.mode == ST_OFF) begin
        r.cmd = 1'b1;
        r.abn = 1'b0;
        r.drive = 1'b1;
        r.mode = ST_ONREQ;
        r.fault = F_NONE;
        r.state_t = req_i.now;
      end else begin
        flags_o.ok = 1'b0;
      end
    end
    rec_o = r;
  end

endmodule
`default_nettype wire

/* sv/cgs_merge.sv */
// Merge stage: folds the lane records and flags into one result.
`default_nettype none
module cgs_merge
  import cgs_pkg::*;
#(
  parameter int GROUPS = 8
) (
  input  wire grp_rec_t    rec_i [GROUPS],
  input  wire lane_flags_t flags_i [GROUPS],
  input  wire logic [2:0]  op_i,
  input  wire logic [3:0]  group_i,
  output logic             ok_o,
  output logic [2:0]       group_state_o,
  output logic [2:0]       group_fault_o,
  output logic [7:0]       drive_mask_o,
  output logic [7:0]       commanded_mask_o,
  output logic [7:0]       confirmed_mask_o,
  output logic [7:0]       faulted_mask_o,
  output logic [7:0]       new_fault_mask_o,
  output logic [7:0]       cleared_mask_o
);

  localparam int NM = (GROUPS < 8) ? GROUPS : 8;

  // Masks over the groups that have feedback bits, and the addressed group.
  always_comb begin
    logic all_ok;
    logic valid;
    all_ok = 1'b1;
    drive_mask_o = '0;
    commanded_mask_o = '0;
    confirmed_mask_o = '0;
    faulted_mask_o = '0;
    new_fault_mask_o = '0;
    cleared_mask_o = '0;
    for (int g = 0; g < GROUPS; g++) begin
      all_ok = all_ok & flags_i[g].ok;
    end
    for (int g = 0; g < NM; g++) begin
      drive_mask_o[g] = rec_i[g].drive;
      commanded_mask_o[g] = rec_i[g].cmd;
      confirmed_mask_o[g] = rec_i[g].mode == ST_ONCONF;
      faulted_mask_o[g] = rec_faulted(rec_i[g]);
      new_fault_mask_o[g] = flags_i[g].new_fault;
      cleared_mask_o[g] = flags_i[g].cleared;
    end
    valid = 32'(group_i) < GROUPS;
    group_state_o = ST_FAULT;
    group_fault_o = F_NONE;
    for (int g = 0; g < GROUPS; g++) begin
      if (32'(group_i) == g) begin
        group_state_o = rec_i[g].mode;
        group_fault_o = rec_i[g].fault;
      end
    end
    case (op_e'(op_i))
      OP_ON, OP_OFF, OP_CLEAR: ok_o = valid && all_ok;
      OP_CLEAR_ALL: ok_o = all_ok;
      default: ok_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire
